// File: design/qafp_pkg.sv
// Shared types and constants for the QUIC ACK frame parser.
// No dependencies; imported by every module of the parser.
`default_nettype none

package qafp_pkg;

	// Frame type bytes
	localparam logic [7:0] TYPE_ACK     = 8'h02;
	localparam logic [7:0] TYPE_ACK_ECN = 8'h03;

	// Default delay exponent when the register holds zero
	localparam logic [4:0] DEFAULT_EXP = 5'd3;

	// Parse phases
	localparam int PHASE_W = 4;
	localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
	localparam logic [PHASE_W-1:0] PH_LARGEST = 4'd1;
	localparam logic [PHASE_W-1:0] PH_DELAY   = 4'd2;
	localparam logic [PHASE_W-1:0] PH_COUNT   = 4'd3;
	localparam logic [PHASE_W-1:0] PH_FIRST   = 4'd4;
	localparam logic [PHASE_W-1:0] PH_GAP     = 4'd5;
	localparam logic [PHASE_W-1:0] PH_LEN     = 4'd6;
	localparam logic [PHASE_W-1:0] PH_ECT0    = 4'd7;
	localparam logic [PHASE_W-1:0] PH_ECT1    = 4'd8;
	localparam logic [PHASE_W-1:0] PH_CE      = 4'd9;

	// Result kinds
	localparam logic [2:0] K_RANGE = 3'd0;
	localparam logic [2:0] K_DELAY = 3'd1;
	localparam logic [2:0] K_ECT0  = 3'd2;
	localparam logic [2:0] K_ECT1  = 3'd3;
	localparam logic [2:0] K_CE    = 3'd4;
	localparam logic [2:0] K_DONE  = 3'd5;
	localparam logic [2:0] K_ERROR = 3'd6;

	// Error codes
	localparam logic [1:0] E_TYPE  = 2'd0;
	localparam logic [1:0] E_TRUNC = 2'd1;
	localparam logic [1:0] E_RANGE = 2'd2;
	localparam logic [1:0] E_GAP   = 2'd3;

	// Result queue geometry
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	// One result item
	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] first_value;
		logic [61:0] second_value;
		logic [15:0] bytes_used;
		logic [1:0]  err_code;
		logic        final_item;
	} result_t;

	// Queue write strobes: slot a first, slot b only together with a
	typedef struct packed {
		logic a;
		logic b;
	} push_t;

endpackage

`default_nettype wire

// File: design/quic_ack_frame_parser.sv
// Top level of the QUIC ACK frame parser: config register, decoder, result queue.
// Depends on qafp_pkg, qafp_decode and qafp_result_fifo.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     data_byte, frame_start, buffer_end
//   out      output     out_valid / out_ready   kind, first_value, second_value,
//                                                bytes_used, err_code, final_item
//   cfg      input      cfg_valid / cfg_ready   delay_exponent
//
// One byte is taken per cycle while the result queue has room; a byte is held in the
// input register and its results are then written into the queue, whose head drives the outputs.
// A byte yields at most two results and the output drains one per cycle while out_ready
// is high, so a run of two-result bytes slows intake to the output rate.
// Input ready drops while a byte is held and the four-entry result queue has
// fewer than two free slots. Reset leaves the parser idle with the exponent at 3.
// Configuration writes are always taken.
`default_nettype none

module quic_ack_frame_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_start,
	input  wire logic        buffer_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [63:0]      first_value,
	output logic [61:0]      second_value,
	output logic [15:0]      bytes_used,
	output logic [1:0]       err_code,
	output logic             final_item,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [4:0]  delay_exponent
);
	import qafp_pkg::*;

	logic [4:0] exp_q;
	logic       room;
	push_t      push;
	result_t    res_a;
	result_t    res_b;
	result_t    head;

	// Delay exponent register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= DEFAULT_EXP;
		end else if (cfg_valid) begin
			exp_q <= delay_exponent;
		end
	end

	qafp_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.buffer_end  (buffer_end),
		.exp_cfg     (exp_q),
		.room        (room),
		.push        (push),
		.res_a       (res_a),
		.res_b       (res_b)
	);

	qafp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res_a     (res_a),
		.res_b     (res_b),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	// Result fields from the queue head
	assign kind         = head.kind;
	assign first_value  = head.first_value;
	assign second_value = head.second_value;
	assign bytes_used   = head.bytes_used;
	assign err_code     = head.err_code;
	assign final_item   = head.final_item;

endmodule

`default_nettype wire

// File: design/qafp_decode.sv
// Byte decoder: input register, varint assembly, frame state and result build.
// Depends on qafp_pkg; feeds up to two results per byte into qafp_result_fifo.
`default_nettype none

module qafp_decode (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  frame_start,
	input  wire logic                  buffer_end,
	input  wire logic [4:0]            exp_cfg,
	input  wire logic                  room,
	output qafp_pkg::push_t            push,
	output qafp_pkg::result_t          res_a,
	output qafp_pkg::result_t          res_b
);
	import qafp_pkg::*;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       end_s1;

	// Frame state
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [61:0]        acc_q, acc_d;
	logic [2:0]         left_q, left_d;
	logic [61:0]        largest_q, largest_d;
	logic [61:0]        low_q, low_d;
	logic [61:0]        top_q, top_d;
	logic               gerr_q, gerr_d;
	logic [61:0]        ranges_q, ranges_d;
	logic               ecn_q, ecn_d;
	logic [15:0]        cnt_q, cnt_d;

	logic fire;
	logic in_fire;

	// Datapath terms
	logic [61:0] acc_nx;
	logic [2:0]  left_nx;
	logic [62:0] first_diff;
	logic [63:0] gap_diff;
	logic [62:0] len_diff;
	logic [4:0]  exp_eff;
	logic [63:0] delay_val;
	logic [61:0] ranges_dec;
	logic [15:0] cnt_inc;
	logic        type_ok;

	// Result staging
	logic    has_main;
	logic    has_tail;
	logic    error;
	logic    finished;
	result_t main_res;
	result_t tail_res;

	function automatic result_t mk_res(input logic [2:0] k, input logic [63:0] f,
			input logic [61:0] s, input logic [15:0] b, input logic [1:0] e,
			input logic fin);
		result_t r;
		r.kind         = k;
		r.first_value  = f;
		r.second_value = s;
		r.bytes_used   = b;
		r.err_code     = e;
		r.final_item   = fin;
		return r;
	endfunction

	// Handshake: the held byte is processed once the queue has two free slots
	assign fire     = valid_s1 & room;
	assign in_ready = ~valid_s1 | room;
	assign in_fire  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1  <= data_byte;
			start_s1 <= frame_start;
			end_s1   <= buffer_end;
		end
	end

	// Varint assembly: first byte carries length in its top two bits
	always_comb begin
		if (left_q == 3'd0) begin
			acc_nx = {56'd0, byte_s1[5:0]};
			case (byte_s1[7:6])
				2'd0:    left_nx = 3'd0;
				2'd1:    left_nx = 3'd1;
				2'd2:    left_nx = 3'd3;
				default: left_nx = 3'd7;
			endcase
		end else begin
			acc_nx  = {acc_q[53:0], byte_s1};
			left_nx = left_q - 3'd1;
		end
	end

	// Range arithmetic; the top bit of each difference is the borrow
	assign first_diff = {1'b0, largest_q} - {1'b0, acc_nx};
	assign gap_diff   = {2'b00, low_q} - {2'b00, acc_nx} - 64'd2;
	assign len_diff   = {1'b0, top_q} - {1'b0, acc_nx};
	assign exp_eff    = (exp_cfg == 5'd0) ? DEFAULT_EXP : exp_cfg;
	assign delay_val  = {2'b00, acc_nx} << exp_eff;
	assign ranges_dec = ranges_q - 62'd1;
	assign cnt_inc    = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
	assign type_ok    = (byte_s1 == TYPE_ACK) || (byte_s1 == TYPE_ACK_ECN);

	// Next state and results for the byte in the input register
	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		left_d    = left_q;
		largest_d = largest_q;
		low_d     = low_q;
		top_d     = top_q;
		gerr_d    = gerr_q;
		ranges_d  = ranges_q;
		ecn_d     = ecn_q;
		cnt_d     = cnt_q;
		has_main  = 1'b0;
		has_tail  = 1'b0;
		error     = 1'b0;
		finished  = 1'b0;
		main_res  = '0;
		tail_res  = '0;

		if (fire) begin
			if (start_s1) begin
				// New frame: type byte
				phase_d = PH_IDLE;
				left_d  = 3'd0;
				acc_d   = '0;
				cnt_d   = 16'd1;
				if (!type_ok) begin
					has_main = 1'b1;
					main_res = mk_res(K_ERROR, 64'd0, 62'd0, 16'd1, E_TYPE, 1'b1);
				end else begin
					ecn_d   = byte_s1[0];
					phase_d = PH_LARGEST;
					if (end_s1) begin
						has_main = 1'b1;
						main_res = mk_res(K_ERROR, 64'd0, 62'd0, 16'd1, E_TRUNC, 1'b1);
						phase_d  = PH_IDLE;
					end
				end
			end else if (phase_q != PH_IDLE) begin
				cnt_d  = cnt_inc;
				acc_d  = acc_nx;
				left_d = left_nx;
				if (left_nx != 3'd0) begin
					// Varint still open
					if (end_s1) begin
						has_main = 1'b1;
						main_res = mk_res(K_ERROR, 64'd0, 62'd0, cnt_inc, E_TRUNC, 1'b1);
						phase_d  = PH_IDLE;
						left_d   = 3'd0;
					end
				end else begin
					// Field complete
					case (phase_q)
						PH_LARGEST: begin
							largest_d = acc_nx;
							phase_d   = PH_DELAY;
						end
						PH_DELAY: begin
							has_main = 1'b1;
							main_res = mk_res(K_DELAY, delay_val, 62'd0, cnt_inc, 2'd0, 1'b0);
							phase_d  = PH_COUNT;
						end
						PH_COUNT: begin
							ranges_d = acc_nx;
							phase_d  = PH_FIRST;
						end
						PH_FIRST: begin
							has_main = 1'b1;
							if (first_diff[62]) begin
								main_res = mk_res(K_ERROR, 64'd0, 62'd0, cnt_inc, E_RANGE,
									1'b1);
								error    = 1'b1;
							end else begin
								low_d    = first_diff[61:0];
								main_res = mk_res(K_RANGE, {2'b00, first_diff[61:0]}, largest_q,
									cnt_inc, 2'd0, 1'b0);
								if (ranges_q != 62'd0) begin
									phase_d = PH_GAP;
								end else if (ecn_q) begin
									phase_d = PH_ECT0;
								end else begin
									phase_d  = PH_IDLE;
									finished = 1'b1;
								end
							end
						end
						PH_GAP: begin
							// Precompute the next range top and its underflow
							top_d   = gap_diff[61:0];
							gerr_d  = gap_diff[63];
							phase_d = PH_LEN;
						end
						PH_LEN: begin
							has_main = 1'b1;
							if (gerr_q) begin
								main_res = mk_res(K_ERROR, 64'd0, 62'd0, cnt_inc, E_GAP, 1'b1);
								error    = 1'b1;
							end else if (len_diff[62]) begin
								main_res = mk_res(K_ERROR, 64'd0, 62'd0, cnt_inc, E_RANGE,
									1'b1);
								error    = 1'b1;
							end else begin
								low_d    = len_diff[61:0];
								ranges_d = ranges_dec;
								main_res = mk_res(K_RANGE, {2'b00, len_diff[61:0]}, top_q,
									cnt_inc, 2'd0, 1'b0);
								if (ranges_dec != 62'd0) begin
									phase_d = PH_GAP;
								end else if (ecn_q) begin
									phase_d = PH_ECT0;
								end else begin
									phase_d  = PH_IDLE;
									finished = 1'b1;
								end
							end
						end
						PH_ECT0: begin
							has_main = 1'b1;
							main_res = mk_res(K_ECT0, {2'b00, acc_nx}, 62'd0, cnt_inc, 2'd0,
								1'b0);
							phase_d  = PH_ECT1;
						end
						PH_ECT1: begin
							has_main = 1'b1;
							main_res = mk_res(K_ECT1, {2'b00, acc_nx}, 62'd0, cnt_inc, 2'd0,
								1'b0);
							phase_d  = PH_CE;
						end
						default: begin
							has_main = 1'b1;
							main_res = mk_res(K_CE, {2'b00, acc_nx}, 62'd0, cnt_inc, 2'd0,
								1'b0);
							phase_d  = PH_IDLE;
							finished = 1'b1;
						end
					endcase

					// Frame end: error closes, done follows last field, else truncation at buffer end
					if (error) begin
						phase_d = PH_IDLE;
					end else if (finished) begin
						has_tail = 1'b1;
						tail_res = mk_res(K_DONE, 64'd0, 62'd0, cnt_inc, 2'd0, 1'b1);
						phase_d  = PH_IDLE;
					end else if (end_s1) begin
						has_tail = 1'b1;
						tail_res = mk_res(K_ERROR, 64'd0, 62'd0, cnt_inc, E_TRUNC, 1'b1);
						phase_d  = PH_IDLE;
					end
				end
			end
		end
	end

	// Results in order: main first, tail second
	always_comb begin
		push.a = has_main | has_tail;
		push.b = has_main & has_tail;
		res_a  = has_main ? main_res : tail_res;
		res_b  = tail_res;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			left_q  <= 3'd0;
			cnt_q   <= 16'd0;
			ecn_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			left_q  <= left_d;
			cnt_q   <= cnt_d;
			ecn_q   <= ecn_d;
		end
	end

	// Values, always written before they are read within a frame
	always_ff @(posedge clk) begin
		acc_q     <= acc_d;
		largest_q <= largest_d;
		low_q     <= low_d;
		top_q     <= top_d;
		gerr_q    <= gerr_d;
		ranges_q  <= ranges_d;
	end

endmodule

`default_nettype wire

// File: design/qafp_result_fifo.sv
// Small result queue: up to two writes and one read per cycle.
// Depends on qafp_pkg for result_t, push_t and the queue geometry.
`default_nettype none

module qafp_result_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  qafp_pkg::push_t        push,
	input  qafp_pkg::result_t      res_a,
	input  qafp_pkg::result_t      res_b,
	output logic                   room,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output qafp_pkg::result_t      head
);
	import qafp_pkg::*;

	result_t              mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_q;
	logic [RES_PTR_W-1:0] rd_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic [RES_PTR_W-1:0] wr_nx1;
	logic                 pop;

	assign wr_nx1    = wr_q + RES_PTR_W'(1);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid & out_ready;
	assign head      = mem_q[rd_q];
	// Two free slots needed before a byte may produce its results
	assign room      = (cnt_q <= RES_CNT_W'(RES_DEPTH - 2));

	// Storage
	always_ff @(posedge clk) begin
		if (push.a) begin
			mem_q[wr_q] <= res_a;
		end
		if (push.b) begin
			mem_q[wr_nx1] <= res_b;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + RES_PTR_W'(push.a) + RES_PTR_W'(push.b);
			rd_q  <= rd_q + RES_PTR_W'(pop);
			cnt_q <= cnt_q + RES_CNT_W'(push.a) + RES_CNT_W'(push.b) - RES_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire
